[rtl/core/dts_pkg.sv]
// Shared types, constants and helpers for the delimiter token splitter.
// No dependencies; every other file in rtl/core refers to this package by scope.
package dts_pkg;

  localparam int SEP_MAX   = 4;   // longest separator, in bytes (1 to 8)
  localparam int POS_BITS  = 16;  // width of the position counters (8 to 32)
  localparam int OUT_BITS  = 16;  // width of reported offsets and lengths
  localparam int SEP_REG_BYTES = 4;  // bytes held by the separator register
  localparam int RECENT_DEPTH  = (SEP_MAX > 1) ? SEP_MAX - 1 : 1;
  localparam int LEN_BITS      = $clog2(SEP_MAX + 1);
  localparam int QUEUE_DEPTH   = 4;  // power of two, at least 2
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [POS_BITS:0]   span_t;
  typedef logic [OUT_BITS-1:0] field_t;
  typedef logic [LEN_BITS-1:0] len_t;
  typedef logic [QPTR_BITS-1:0] qptr_t;
  typedef logic [QCNT_BITS-1:0] qcnt_t;

  localparam pos_t POS_MAX = '1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LINE_MODE  = 2'd0,
    CFG_EMIT_EMPTY = 2'd1,
    CFG_SEP_LENGTH = 2'd2,
    CFG_SEPARATOR  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic        line_mode;
    logic        emit_empty;
    logic [2:0]  sep_length;
    logic [31:0] separator;
  } cfg_t;

  typedef struct packed {
    logic   has_token;
    field_t token_start;
    field_t token_length;
    logic   string_done;
  } result_t;

  // Up to two result words produced by one accepted byte, in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic pos_t sat_inc(input pos_t v);
    sat_inc = (v == POS_MAX) ? v : v + pos_t'(1);
  endfunction

endpackage

[rtl/core/dts_config.sv]
// Configuration register file for the delimiter token splitter.
// Depends on dts_pkg for the register index codes and the cfg_t bundle.
module dts_config (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [dts_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [dts_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output dts_pkg::cfg_t                        cfg
);

  dts_pkg::cfg_index_t index;

  assign index = dts_pkg::cfg_index_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_mode  <= 1'b0;
      cfg.emit_empty <= 1'b0;
      cfg.sep_length <= 3'd1;
      cfg.separator  <= 32'd44;
    end else if (cfg_write) begin
      unique case (index)
        dts_pkg::CFG_LINE_MODE:  cfg.line_mode  <= cfg_data[0];
        dts_pkg::CFG_EMIT_EMPTY: cfg.emit_empty <= cfg_data[0];
        dts_pkg::CFG_SEP_LENGTH: cfg.sep_length <= cfg_data[2:0];
        dts_pkg::CFG_SEPARATOR:  cfg.separator  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/dts_step.sv]
// Per-byte tokenizer step: string state registers and the match/split logic.
// Depends on dts_pkg for types, constants and the saturating increment.
module dts_step (
  input  logic           clk,
  input  logic           rst,
  input  dts_pkg::cfg_t  cfg,
  input  logic           accept,
  input  logic [7:0]     text_byte,
  input  logic           final_byte,
  output dts_pkg::push_t push
);

  dts_pkg::pos_t byte_position;
  dts_pkg::pos_t current_start;
  logic [7:0]    recent_bytes [dts_pkg::RECENT_DEPTH];
  logic          after_cr;

  logic [7:0]         win   [dts_pkg::SEP_MAX];
  logic [7:0]         sep_b [dts_pkg::SEP_MAX];
  logic [dts_pkg::SEP_MAX-1:0] hit;
  logic               sel_hit;
  dts_pkg::len_t      len_eff;
  dts_pkg::span_t     span;
  dts_pkg::span_t     tlen;
  dts_pkg::span_t     tok_len;
  dts_pkg::span_t     tail;
  dts_pkg::pos_t      start_after;
  dts_pkg::pos_t      pos_inc;
  logic               after_cr_next;
  logic               tok_valid;
  logic               tail_valid;
  logic               emit;
  logic               is_lf;
  logic               is_cr;
  dts_pkg::result_t   tok;
  dts_pkg::result_t   tail_res;

  assign is_lf   = (text_byte == dts_pkg::BYTE_LF);
  assign is_cr   = (text_byte == dts_pkg::BYTE_CR);
  assign pos_inc = dts_pkg::sat_inc(byte_position);
  // bytes from the current token start up to and including this one
  assign span    = {1'b0, byte_position} - {1'b0, current_start} + dts_pkg::span_t'(1);

  // window: newest byte first, and the separator split into bytes
  always_comb begin
    win[0] = text_byte;
    for (int d = 1; d < dts_pkg::SEP_MAX; d++) begin
      win[d] = recent_bytes[d-1];
    end
    for (int k = 0; k < dts_pkg::SEP_MAX; k++) begin
      if (k < dts_pkg::SEP_REG_BYTES) begin
        sep_b[k] = cfg.separator[8*k +: 8];
      end else begin
        sep_b[k] = 8'h00;
      end
    end
  end

  // compare every separator length in parallel, then pick the one in use
  always_comb begin
    for (int l = 1; l <= dts_pkg::SEP_MAX; l++) begin
      hit[l-1] = 1'b1;
      for (int j = 0; j < l; j++) begin
        if (win[l-1-j] != sep_b[j]) begin
          hit[l-1] = 1'b0;
        end
      end
    end
    priority if (cfg.sep_length == 3'd0) begin
      len_eff = dts_pkg::len_t'(1);
    end else if (int'(cfg.sep_length) > dts_pkg::SEP_MAX) begin
      len_eff = dts_pkg::len_t'(dts_pkg::SEP_MAX);
    end else begin
      len_eff = dts_pkg::len_t'(cfg.sep_length);
    end
    sel_hit = 1'b0;
    for (int l = 1; l <= dts_pkg::SEP_MAX; l++) begin
      if (int'(len_eff) == l) begin
        sel_hit = hit[l-1];
      end
    end
  end

  assign tlen = span - dts_pkg::span_t'(len_eff);

  always_comb begin
    start_after   = current_start;
    after_cr_next = 1'b0;
    tok_valid     = 1'b0;
    tok_len       = '0;
    if (cfg.line_mode) begin
      if (is_lf) begin
        if (after_cr) begin
          // LF of a CRLF pair: skip it
          start_after = pos_inc;
        end else begin
          tok_valid   = 1'b1;
          tok_len     = span - dts_pkg::span_t'(1);
          start_after = pos_inc;
        end
      end else if (is_cr) begin
        tok_valid     = 1'b1;
        tok_len       = span - dts_pkg::span_t'(1);
        start_after   = pos_inc;
        after_cr_next = 1'b1;
      end
    end else if (sel_hit && (span >= dts_pkg::span_t'(len_eff))) begin
      tok_valid   = (tlen != '0) || cfg.emit_empty;
      tok_len     = tlen;
      start_after = pos_inc;
    end
  end

  assign tail = ({1'b0, byte_position} + dts_pkg::span_t'(1)) - {1'b0, start_after};
  assign emit = (tail != '0) || (!cfg.line_mode && cfg.emit_empty);

  always_comb begin
    tok.has_token    = 1'b1;
    tok.token_start  = dts_pkg::field_t'(current_start);
    tok.token_length = dts_pkg::field_t'(tok_len);
    // a final byte with no tail marks the token it ended
    tok.string_done  = final_byte && !emit;

    if (emit) begin
      tail_res.has_token    = 1'b1;
      tail_res.token_start  = dts_pkg::field_t'(start_after);
      tail_res.token_length = dts_pkg::field_t'(tail);
    end else begin
      tail_res.has_token    = 1'b0;
      tail_res.token_start  = '0;
      tail_res.token_length = '0;
    end
    tail_res.string_done = 1'b1;

    tail_valid = final_byte && (emit || !tok_valid);

    push.first  = tok_valid ? tok : tail_res;
    push.second = tail_res;
    if (accept) begin
      push.count = {1'b0, tok_valid} + {1'b0, tail_valid};
    end else begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      current_start <= '0;
      after_cr      <= 1'b0;
      for (int d = 0; d < dts_pkg::RECENT_DEPTH; d++) begin
        recent_bytes[d] <= 8'h00;
      end
    end else if (accept) begin
      if (final_byte) begin
        byte_position <= '0;
        current_start <= '0;
        after_cr      <= 1'b0;
        for (int d = 0; d < dts_pkg::RECENT_DEPTH; d++) begin
          recent_bytes[d] <= 8'h00;
        end
      end else begin
        byte_position   <= pos_inc;
        current_start   <= start_after;
        after_cr        <= after_cr_next;
        recent_bytes[0] <= text_byte;
        for (int d = 1; d < dts_pkg::RECENT_DEPTH; d++) begin
          recent_bytes[d] <= recent_bytes[d-1];
        end
      end
    end
  end

endmodule

[rtl/core/dts_queue.sv]
// Result queue: takes up to two result words per cycle, hands out one while out_ready is high.
// Depends on dts_pkg for the result and push bundles and the queue sizing.
module dts_queue (
  input  logic             clk,
  input  logic             rst,
  input  dts_pkg::push_t   push,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output dts_pkg::result_t head
);

  dts_pkg::result_t entries [dts_pkg::QUEUE_DEPTH];
  dts_pkg::qptr_t   wr_ptr;
  dts_pkg::qptr_t   rd_ptr;
  dts_pkg::qcnt_t   count;
  dts_pkg::qcnt_t   count_next;
  logic             pop;

  assign out_valid = (count != '0);
  assign head      = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  // room for the worst case of one byte: two words
  assign space     = (count <= dts_pkg::qcnt_t'(dts_pkg::QUEUE_DEPTH - 2));

  assign count_next = count + dts_pkg::qcnt_t'(push.count) - dts_pkg::qcnt_t'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + dts_pkg::qptr_t'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + dts_pkg::qptr_t'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + dts_pkg::qptr_t'(1);
      end
      count <= count_next;
    end
  end

endmodule

[rtl/core/delimiter_token_splitter_top.sv]
// Top level of the delimiter token splitter: config registers, tokenizer step
// and result queue. Depends on dts_pkg, dts_config, dts_step and dts_queue.
//
// Streams a string in one byte per word and reports each token as a start
// offset and a length. Split mode (line_mode 0) cuts on a separator of
// sep_length bytes (0 acts as 1, above 4 acts as 4), leftmost match first,
// never overlapping; zero-length tokens and an empty tail appear only with
// emit_empty set. Line mode cuts on CR, LF and CRLF, keeps empty lines and
// drops an empty tail. The word flagged final_byte closes the string: its
// last result word carries string_done, and if it ends no token a bare end
// marker (has_token 0, zero offset and length) is sent instead. Offsets
// saturate at 65535. Rate: one byte is taken every cycle while in_ready is
// high; all the work on a byte is combinational compare logic against the
// three previous bytes, and its results sit in a four-word queue from the
// cycle after acceptance. A byte gives zero, one or two result words and the
// queue drains one per cycle while out_ready is high, so in_ready drops while
// fewer than two slots are free. A configuration write applies from the next
// accepted byte, even inside a string; write it with no byte being offered in
// the same cycle.
module delimiter_token_splitter_top (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_write,
  input  logic [dts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [dts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // input words
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         text_byte,
  input  logic                               final_byte,
  // result words
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               has_token,
  output logic [dts_pkg::OUT_BITS-1:0]       token_start,
  output logic [dts_pkg::OUT_BITS-1:0]       token_length,
  output logic                               string_done
);

  dts_pkg::cfg_t    cfg;
  dts_pkg::push_t   push;
  dts_pkg::result_t head;
  logic             accept;

  // take a byte only when the queue can absorb both of its possible words
  assign accept = in_valid && in_ready;

  dts_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // match/split logic plus position, token start, window and CR flag
  dts_step u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .push       (push)
  );

  // hold result words until the consumer takes them
  dts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign has_token    = head.has_token;
  assign token_start  = head.token_start;
  assign token_length = head.token_length;
  assign string_done  = head.string_done;

endmodule
